// ===== design/clx_rng_pkg.sv =====
// Package for the combined congruential / multiply-with-carry / xorshift generator.
// Holds the command codes, generator constants and the state word type.
// No dependencies.
package clx_rng_pkg;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 16;
    localparam int CMD_W   = 2;

    // Command codes. The unused code behaves as a state read.
    localparam logic [CMD_W-1:0] CMD_NEXT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    // Generator constants.
    localparam logic [WORD_W-1:0] LCG_MUL     = 32'd69069;
    localparam logic [WORD_W-1:0] LCG_ADD     = 32'd262145;
    localparam logic [15:0]       MWC_MUL     = 16'd36969;
    localparam logic [WORD_W-1:0] LCG_RESET   = 32'd1;
    localparam logic [WORD_W-1:0] MWC_DEFAULT = 32'd362436069;
    localparam logic [WORD_W-1:0] XS_DEFAULT  = 32'd123456789;

    // The three generator words.
    typedef struct packed {
        logic [WORD_W-1:0] lcg;
        logic [WORD_W-1:0] mwc;
        logic [WORD_W-1:0] xs;
    } rng_state_t;

endpackage

// ===== design/clx_rng_step.sv =====
// Combinational update of the three generator words for one command.
// Depends on clx_rng_pkg for the command codes, constants and state type.
module clx_rng_step
(
    input  logic [clx_rng_pkg::CMD_W-1:0]   cmd,
    input  logic [clx_rng_pkg::WORD_W-1:0]  seed_lcg,
    input  logic [clx_rng_pkg::WORD_W-1:0]  seed_mwc,
    input  logic [clx_rng_pkg::WORD_W-1:0]  seed_xs,
    input  clx_rng_pkg::rng_state_t         state_cur,
    output clx_rng_pkg::rng_state_t         state_new,
    output logic [clx_rng_pkg::VALUE_W-1:0] value
);

    logic [clx_rng_pkg::WORD_W-1:0] lcg_adv;
    logic [clx_rng_pkg::WORD_W-1:0] mwc_src;
    logic [clx_rng_pkg::WORD_W-1:0] mwc_prod;
    logic [clx_rng_pkg::WORD_W-1:0] mwc_adv;
    logic [clx_rng_pkg::WORD_W-1:0] xs_src;
    logic [clx_rng_pkg::WORD_W-1:0] xs_a;
    logic [clx_rng_pkg::WORD_W-1:0] xs_b;
    logic [clx_rng_pkg::WORD_W-1:0] xs_adv;
    logic [clx_rng_pkg::WORD_W-1:0] mix;

    // Congruential word: one 32 x 17 constant multiply, wrapped to 32 bits.
    assign lcg_adv = clx_rng_pkg::WORD_W'(state_cur.lcg * clx_rng_pkg::LCG_MUL)
                   + clx_rng_pkg::LCG_ADD;

    // A zero mwc or xs word is replaced by its default before advancing.
    assign mwc_src = (state_cur.mwc == '0) ? clx_rng_pkg::MWC_DEFAULT : state_cur.mwc;
    assign xs_src  = (state_cur.xs == '0)  ? clx_rng_pkg::XS_DEFAULT  : state_cur.xs;

    // Multiply-with-carry: the sum never exceeds 32 bits.
    assign mwc_prod = clx_rng_pkg::WORD_W'(clx_rng_pkg::MWC_MUL) * {16'd0, mwc_src[15:0]};
    assign mwc_adv  = mwc_prod + {16'd0, mwc_src[31:16]};

    assign xs_a   = xs_src ^ (xs_src << 17);
    assign xs_b   = xs_a ^ (xs_a >> 13);
    assign xs_adv = xs_b ^ (xs_b << 5);

    assign mix = lcg_adv ^ (mwc_adv << 16) ^ xs_adv;

    always_comb
    begin
        state_new = state_cur;
        value     = '0;
        case (cmd)
            clx_rng_pkg::CMD_NEXT:
            begin
                state_new.lcg = lcg_adv;
                state_new.mwc = mwc_adv;
                state_new.xs  = xs_adv;
                value         = mix[31:16];
            end
            clx_rng_pkg::CMD_LOAD:
            begin
                state_new.lcg = seed_lcg;
                state_new.mwc = seed_mwc;
                state_new.xs  = seed_xs;
            end
            default:
            begin
                state_new = state_cur;
            end
        endcase
    end

endmodule

// ===== design/combined_lcg_mwc_xorshift_rng_core.sv =====
// Top level of the combined congruential / multiply-with-carry / xorshift generator.
// Depends on clx_rng_pkg and clx_rng_step.
//
// Usage:
// A request on the input channel carries a command and three seed words. The command
// "next" advances all three generator words and returns a 16-bit random value, "load"
// writes the seed words, and "read" (or the unused code) leaves the state alone. Every
// request gives exactly one result on the output channel with the value (zero except
// on "next") and the three words as they stand after the request.
// Both channels use valid/stall: a transfer happens on a rising edge with valid high
// and stall low.
// Timing: a request is captured in an input register; the word update is one pass of
// short logic (two small constant multipliers and the xorshift network) into the
// result register. A taken request moves on from the input register into the result
// register, and one request is taken every cycle while the output side keeps
// draining. Since the state words are updated at the same edge as the result register,
// back-to-back requests always see the words left by the one before.
// Reset: the words return to 1, 362436069 and 123456789, and both stages are empty.
// Stall: while the receiver stalls, the result register holds its result; the input
// register keeps taking one more request and then stalls the sender in turn.
module combined_lcg_mwc_xorshift_rng_core
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [clx_rng_pkg::CMD_W-1:0]       cmd,
    input  logic [clx_rng_pkg::WORD_W-1:0]      seed_lcg,
    input  logic [clx_rng_pkg::WORD_W-1:0]      seed_mwc,
    input  logic [clx_rng_pkg::WORD_W-1:0]      seed_xs,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [clx_rng_pkg::VALUE_W-1:0]     value,
    output logic [clx_rng_pkg::WORD_W-1:0]      state_lcg,
    output logic [clx_rng_pkg::WORD_W-1:0]      state_mwc,
    output logic [clx_rng_pkg::WORD_W-1:0]      state_xs
);

    // Input register.
    logic                              in_vld_reg;
    logic [clx_rng_pkg::CMD_W-1:0]     cmd_reg;
    logic [clx_rng_pkg::WORD_W-1:0]    seed_lcg_reg;
    logic [clx_rng_pkg::WORD_W-1:0]    seed_mwc_reg;
    logic [clx_rng_pkg::WORD_W-1:0]    seed_xs_reg;

    // Generator state and result register.
    clx_rng_pkg::rng_state_t           state_reg;
    clx_rng_pkg::rng_state_t           state_next;
    logic                              out_vld_reg;
    logic [clx_rng_pkg::VALUE_W-1:0]   value_reg;
    logic [clx_rng_pkg::VALUE_W-1:0]   value_next;
    clx_rng_pkg::rng_state_t           res_reg;

    logic                              advance;
    logic                              in_take;

    // The captured request moves on when the result register is empty or being drained.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    clx_rng_step u_step
    (
        .cmd       (cmd_reg),
        .seed_lcg  (seed_lcg_reg),
        .seed_mwc  (seed_mwc_reg),
        .seed_xs   (seed_xs_reg),
        .state_cur (state_reg),
        .state_new (state_next),
        .value     (value_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            state_reg.lcg <= clx_rng_pkg::LCG_RESET;
            state_reg.mwc <= clx_rng_pkg::MWC_DEFAULT;
            state_reg.xs  <= clx_rng_pkg::XS_DEFAULT;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg      <= cmd;
            seed_lcg_reg <= seed_lcg;
            seed_mwc_reg <= seed_mwc;
            seed_xs_reg  <= seed_xs;
        end
        if (advance)
        begin
            value_reg <= value_next;
            res_reg   <= state_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign value     = value_reg;
    assign state_lcg = res_reg.lcg;
    assign state_mwc = res_reg.mwc;
    assign state_xs  = res_reg.xs;

    // The sender is only stalled while a request is waiting in the input register.
    a_stall_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg)
        else $error("input stalled with an empty input register");

    // The generator words change only when a request is processed.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("generator state changed without a request");

    // A processed request always produces a result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("processed request left no result");

    // After a next command the multiply-with-carry and xorshift words are never zero.
    a_next_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && cmd_reg == clx_rng_pkg::CMD_NEXT)
        |=> (state_reg.mwc != '0 && state_reg.xs != '0))
        else $error("zero generator word after a next command");

endmodule
